// ----- hw/rtl/cta_pkg.sv -----
package cta_pkg;

  localparam int SLOTS    = 16;
  localparam int KEY_BITS = 48;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 48;
  localparam int ID_W     = 16;
  localparam int MS_W     = 16;
  localparam int AGE_W    = 16;
  localparam int LIMIT_W  = 16;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 4;
  localparam int BIT_W    = 16;

  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_ST_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  localparam logic [LIMIT_W-1:0] STALE_RESET = LIMIT_W'(1000);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NONE      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  peer_key;
    logic [ID_W-1:0]   sender_id;
    logic [MS_W-1:0]   elapsed_ms;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] slot_index;
    logic [BIT_W-1:0] slot_bit;
    logic [KEY_W-1:0] entry_key;
    logic [ID_W-1:0]  entry_id;
  } out_item_t;

  typedef struct packed {
    logic             hit;
    logic             stale;
    logic [AGE_W-1:0] age_sum;
  } lane_stat_t;

  typedef struct packed {
    logic [SLOTS-1:0] hit_oh;
    logic [SLOTS-1:0] free_oh;
    logic [SLOTS-1:0] stale_oh;
  } pick_t;

  function automatic logic [SLOTS-1:0] lowest_oh(input logic [SLOTS-1:0] v);
    return v & (~v + SLOTS'(1));
  endfunction

  function automatic logic [SLOTS-1:0] bit_rev(input logic [SLOTS-1:0] v);
    logic [SLOTS-1:0] r;
    for (int i = 0; i < SLOTS; i++) begin
      r[i] = v[SLOTS-1-i];
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] enc(input logic [SLOTS-1:0] oh);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (oh[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- hw/rtl/cta_lane.sv -----
module cta_lane
  import cta_pkg::*;
(
  input  logic                valid,
  input  logic [KEY_ST_W-1:0] key,
  input  logic [AGE_W-1:0]    age,
  input  logic [KEY_ST_W-1:0] key_in,
  input  logic [MS_W-1:0]     ms,
  input  logic [LIMIT_W-1:0]  limit,
  output lane_stat_t          stat
);

  logic [AGE_W:0]   sum;
  logic [AGE_W-1:0] sat;

  assign sum = {1'b0, age} + (AGE_W + 1)'(ms);
  assign sat = sum[AGE_W] ? {AGE_W{1'b1}} : sum[AGE_W-1:0];

  assign stat.hit     = valid && (key == key_in);
  assign stat.stale   = valid && (sat >= AGE_W'(limit));
  assign stat.age_sum = sat;

endmodule

// ----- hw/rtl/cta_pick.sv -----
module cta_pick
  import cta_pkg::*;
(
  input  logic [SLOTS-1:0] valid,
  input  logic [SLOTS-1:0] hit,
  input  logic [SLOTS-1:0] stale,
  output pick_t            pick
);

  logic [SLOTS-1:0] hit_oh;

  // add frees a duplicate first, so the freed slot counts as free
  assign hit_oh        = lowest_oh(hit);
  assign pick.hit_oh   = hit_oh;
  assign pick.free_oh  = lowest_oh(~(valid & ~hit_oh));
  assign pick.stale_oh = bit_rev(lowest_oh(bit_rev(stale)));

endmodule

// ----- hw/rtl/connection_table_with_aging.sv -----
// An accepted request is held in item_r; its result is registered in out_r with out_valid,
// and the table state is written back at the same edge as out_r.
// Throughput: one request per cycle; busy stays low, as every slot is matched
// and aged in parallel in the single stage between input and result registers.
// Results cannot be stalled by the receiver; out_valid is a one-cycle strobe.
// Reset (rst_n low, synchronous) empties the table and sets stale_limit to 1000;
// the table is usable in the first cycle after reset.
module connection_table_with_aging
  import cta_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_item,
  output logic               out_valid,
  output out_item_t          out_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  logic [LIMIT_W-1:0]  limit_r;
  logic                item_vld_r;
  in_item_t            item_r;
  logic [SLOTS-1:0]    valid_r;
  logic [SLOTS-1:0]    valid_nxt;
  logic [KEY_ST_W-1:0] key_r [SLOTS];
  logic [ID_W-1:0]     id_r  [SLOTS];
  logic [AGE_W-1:0]    age_r [SLOTS];
  logic [AGE_W-1:0]    age_nxt [SLOTS];
  logic [SLOTS-1:0]    wr_oh;
  logic                out_vld_r;
  out_item_t           out_r;
  out_item_t           out_nxt;

  lane_stat_t          stat [SLOTS];
  logic [SLOTS-1:0]    hit_v;
  logic [SLOTS-1:0]    stale_v;
  pick_t               pick;
  logic [KEY_ST_W-1:0] key_in;
  logic [SLOTS-1:0]    rd_oh;
  logic [KEY_ST_W-1:0] rd_key;
  logic [ID_W-1:0]     rd_id;
  logic [SLOT_W-1:0]   sel_idx;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign out_valid  = out_vld_r;
  assign out_result = out_r;

  assign key_in = item_r.peer_key[KEY_ST_W-1:0];

  for (genvar g = 0; g < SLOTS; g++) begin : g_lane
    cta_lane u_lane (
      .valid  (valid_r[g]),
      .key    (key_r[g]),
      .age    (age_r[g]),
      .key_in (key_in),
      .ms     (item_r.elapsed_ms),
      .limit  (limit_r),
      .stat   (stat[g])
    );
    assign hit_v[g]   = stat[g].hit;
    assign stale_v[g] = stat[g].stale;
  end

  cta_pick u_pick (
    .valid (valid_r),
    .hit   (hit_v),
    .stale (stale_v),
    .pick  (pick)
  );

  // one read port, selected one-hot
  always_comb begin
    rd_oh = (mode_t'(item_r.mode) == MODE_LOOKUP) ? pick.hit_oh : pick.stale_oh;
    rd_key = '0;
    rd_id  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (rd_oh[i]) begin
        rd_key = rd_key | key_r[i];
        rd_id  = rd_id | id_r[i];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    wr_oh     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      age_nxt[i] = age_r[i];
    end
    out_nxt = '{status: ST_CLEARED, slot_index: '0, slot_bit: '0,
                entry_key: '0, entry_id: '0};
    sel_idx = '0;
    case (mode_t'(item_r.mode))
      MODE_ADD: begin
        if (pick.free_oh != '0) begin
          sel_idx   = enc(pick.free_oh);
          valid_nxt = (valid_r & ~pick.hit_oh) | pick.free_oh;
          wr_oh     = pick.free_oh;
          for (int i = 0; i < SLOTS; i++) begin
            if (pick.free_oh[i]) begin
              age_nxt[i] = '0;
            end
          end
          out_nxt.status     = ST_ADDED;
          out_nxt.slot_index = IDX_W'(sel_idx);
          out_nxt.slot_bit   = BIT_W'(1) << sel_idx;
          out_nxt.entry_key  = KEY_W'(key_in);
          out_nxt.entry_id   = item_r.sender_id;
        end else begin
          out_nxt.status = ST_FULL;
        end
      end
      MODE_LOOKUP: begin
        if (pick.hit_oh != '0) begin
          sel_idx = enc(pick.hit_oh);
          for (int i = 0; i < SLOTS; i++) begin
            if (pick.hit_oh[i]) begin
              age_nxt[i] = '0;
            end
          end
          out_nxt.status     = ST_FOUND;
          out_nxt.slot_index = IDX_W'(sel_idx);
          out_nxt.slot_bit   = BIT_W'(1) << sel_idx;
          out_nxt.entry_key  = KEY_W'(rd_key);
          out_nxt.entry_id   = rd_id;
        end else begin
          out_nxt.status = ST_NOT_FOUND;
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (valid_r[i]) begin
            age_nxt[i] = stat[i].age_sum;
          end
        end
        if (pick.stale_oh != '0) begin
          sel_idx            = enc(pick.stale_oh);
          valid_nxt          = valid_r & ~pick.stale_oh;
          out_nxt.status     = ST_REMOVED;
          out_nxt.slot_index = IDX_W'(sel_idx);
          out_nxt.slot_bit   = BIT_W'(1) << sel_idx;
          out_nxt.entry_key  = KEY_W'(rd_key);
          out_nxt.entry_id   = rd_id;
        end else begin
          out_nxt.status = ST_NONE;
        end
      end
      default: begin
        valid_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= STALE_RESET;
      item_vld_r <= 1'b0;
      valid_r    <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      item_vld_r <= start && !busy;
      out_vld_r  <= item_vld_r;
      if (item_vld_r) begin
        valid_r <= valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_item;
    end
    if (item_vld_r) begin
      out_r <= out_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        age_r[i] <= age_nxt[i];
        if (wr_oh[i]) begin
          key_r[i] <= key_in;
          id_r[i]  <= item_r.sender_id;
        end
      end
    end
  end

endmodule

// ----- bench/tb_connection_table_with_aging.sv -----
module tb_connection_table_with_aging;
  timeunit 1ns;
  timeprecision 1ps;
  import cta_pkg::*;

  localparam int POOL = 24;
  localparam int RAND_PER_PHASE = 292;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_ST_W);
  localparam out_item_t NO_RES = '0;

  typedef struct {
    mode_t            mode;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  sid;
    logic [MS_W-1:0]  ms;
    bit               typed;
    out_item_t        want;
  } script_row_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  in_item_t           in_item   = '0;
  logic               out_valid;
  out_item_t          out_result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data  = '0;

  // predictor copy of the table
  logic               ent_live [SLOTS];
  logic [KEY_W-1:0]   ent_key  [SLOTS];
  logic [ID_W-1:0]    ent_id   [SLOTS];
  logic [AGE_W-1:0]   ent_age  [SLOTS];
  logic [LIMIT_W-1:0] age_limit;

  out_item_t   pending_res [$];
  script_row_t script [$];
  int n_err = 0;
  int n_req = 0;
  int n_res = 0;
  int n_cfg = 0;
  int burst_left = 0;
  int seen [7] = '{default: 0};

  connection_table_with_aging u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic out_item_t slot_res(status_t st, int idx);
    out_item_t r;
    r            = '0;
    r.status     = st;
    r.slot_index = IDX_W'(idx);
    r.slot_bit   = BIT_W'(1) << idx;
    r.entry_key  = ent_key[idx];
    r.entry_id   = ent_id[idx];
    return r;
  endfunction

  function automatic out_item_t conn_table_step(in_item_t req);
    out_item_t        r;
    logic [KEY_W-1:0] k;
    logic [AGE_W:0]   sum;
    int               hit;
    int               pick;
    r    = '0;
    k    = req.peer_key & KEY_MASK;
    hit  = -1;
    pick = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (ent_live[i] && ent_key[i] == k) hit = i;
    end
    case (mode_t'(req.mode))
      MODE_ADD: begin
        if (hit >= 0) ent_live[hit] = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!ent_live[i]) pick = i;
        end
        if (pick >= 0) begin
          ent_live[pick] = 1'b1;
          ent_key[pick]  = k;
          ent_id[pick]   = req.sender_id;
          ent_age[pick]  = '0;
          r = slot_res(ST_ADDED, pick);
        end else begin
          r.status = ST_FULL;
        end
      end
      MODE_LOOKUP: begin
        if (hit >= 0) begin
          ent_age[hit] = '0;
          r = slot_res(ST_FOUND, hit);
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (ent_live[i]) begin
            sum        = {1'b0, ent_age[i]} + req.elapsed_ms;
            ent_age[i] = sum[AGE_W] ? {AGE_W{1'b1}} : sum[AGE_W-1:0];
            if (ent_age[i] >= age_limit) pick = i;
          end
        end
        if (pick >= 0) begin
          r = slot_res(ST_REMOVED, pick);
          ent_live[pick] = 1'b0;
        end else begin
          r.status = ST_NONE;
        end
      end
      default: begin
        foreach (ent_live[i]) ent_live[i] = 1'b0;
        r.status = ST_CLEARED;
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      burst_left = 60;
      return 0;
    end
    if (r < 100) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic issue(input in_item_t req, input int gap, output out_item_t pred);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy !== 1'b0);
    pred = conn_table_step(req);
    n_req++;
  endtask

  // drain: hold requests off until every result is back, then allow for latency
  task automatic settle();
    start <= 1'b0;
    for (int w = 0; w < 2000 && pending_res.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    age_limit = v;
    n_cfg++;
  endtask

  task automatic flag(input string what, input logic [63:0] exp_v, input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      n_err++;
      if (n_err <= 40)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin : res_chk
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      n_res++;
      if (int'(out_result.status) < 7) seen[int'(out_result.status)]++;
      if (pending_res.size() == 0) begin
        n_err++;
        if (n_err <= 40)
          $display("%0t ns: unexpected result, expected none, got %p", $time, out_result);
      end else begin
        want = pending_res.pop_front();
        flag("status", want.status, out_result.status);
        flag("slot_index", want.slot_index, out_result.slot_index);
        flag("slot_bit", want.slot_bit, out_result.slot_bit);
        flag("entry_key", want.entry_key, out_result.entry_key);
        flag("entry_id", want.entry_id, out_result.entry_id);
      end
    end
  end

  initial begin
    in_item_t           req;
    out_item_t          got;
    logic [KEY_W-1:0]   key_pool [POOL];
    logic [LIMIT_W-1:0] limits [6];
    int                 r;

    foreach (ent_live[i]) ent_live[i] = 1'b0;
    age_limit = STALE_RESET;

    script.push_back('{MODE_LOOKUP, 48'd0, 16'd0, 16'd0, 1'b1,
                       '{ST_NOT_FOUND, 4'd0, 16'd0, 48'd0, 16'd0}});
    script.push_back('{MODE_TICK, 48'd0, 16'd0, 16'd0, 1'b1,
                       '{ST_NONE, 4'd0, 16'd0, 48'd0, 16'd0}});
    script.push_back('{MODE_ADD, 48'd0, 16'd0, 16'hFFFF, 1'b1,
                       '{ST_ADDED, 4'd0, 16'h0001, 48'd0, 16'd0}});
    script.push_back('{MODE_ADD, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'd0, 1'b1,
                       '{ST_ADDED, 4'd1, 16'h0002, 48'hFFFF_FFFF_FFFF, 16'hFFFF}});
    script.push_back('{MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 16'd0, 16'd0, 1'b1,
                       '{ST_FOUND, 4'd1, 16'h0002, 48'hFFFF_FFFF_FFFF, 16'hFFFF}});
    // duplicate key frees its old slot first
    script.push_back('{MODE_ADD, 48'hFFFF_FFFF_FFFF, 16'h5A5A, 16'd0, 1'b0, NO_RES});
    for (int s = 2; s < SLOTS; s++)
      script.push_back('{MODE_ADD, 48'hC0DE_0000_0000 | KEY_W'(s * 32'h0001_3579),
                         ID_W'(s * 16'h0F0F), 16'd0, 1'b0, NO_RES});
    script.push_back('{MODE_ADD, 48'h1234_5678_9ABC, 16'h7777, 16'd0, 1'b1,
                       '{ST_FULL, 4'd0, 16'd0, 48'd0, 16'd0}});
    script.push_back('{MODE_ADD, 48'd0, 16'h8000, 16'd0, 1'b0, NO_RES});
    script.push_back('{MODE_TICK, 48'd0, 16'd0, 16'd999, 1'b0, NO_RES});
    script.push_back('{MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 16'd0, 16'd0, 1'b0, NO_RES});
    script.push_back('{MODE_TICK, 48'd0, 16'd0, 16'd1, 1'b0, NO_RES});
    script.push_back('{MODE_TICK, 48'd0, 16'd0, 16'hFFFF, 1'b0, NO_RES});
    script.push_back('{MODE_CLEAR, 48'd0, 16'd0, 16'd0, 1'b1,
                       '{ST_CLEARED, 4'd0, 16'd0, 48'd0, 16'd0}});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      req.mode       = script[i].mode;
      req.peer_key   = script[i].key;
      req.sender_id  = script[i].sid;
      req.elapsed_ms = script[i].ms;
      issue(req, pick_gap(), got);
      pending_res.push_back(script[i].typed ? script[i].want : got);
    end

    limits    = '{16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd200, STALE_RESET};
    limits[3] = LIMIT_W'($urandom_range(1, 65535));
    foreach (limits[p]) begin
      write_limit(limits[p]);
      foreach (key_pool[k]) key_pool[k] = KEY_W'({$urandom(), $urandom()});
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (RAND_PER_PHASE) begin
        if ($urandom_range(0, 249) == 0) settle();
        r = $urandom_range(0, 99);
        if (r < 38)      req.mode = MODE_ADD;
        else if (r < 70) req.mode = MODE_LOOKUP;
        else if (r < 97) req.mode = MODE_TICK;
        else             req.mode = MODE_CLEAR;
        req.peer_key  = ($urandom_range(0, 7) == 0) ? KEY_W'({$urandom(), $urandom()})
                                                     : key_pool[$urandom_range(0, POOL - 1)];
        req.sender_id = ID_W'($urandom());
        case ($urandom_range(0, 9))
          0:       req.elapsed_ms = '0;
          1:       req.elapsed_ms = '1;
          2, 3:    req.elapsed_ms = MS_W'($urandom());
          default: req.elapsed_ms = MS_W'($urandom_range(0, int'(age_limit) / 3 + 1));
        endcase
        issue(req, pick_gap(), got);
        pending_res.push_back(got);
      end
    end

    settle();
    if (pending_res.size() != 0) begin
      n_err += pending_res.size();
      $display("%0t ns: %0d results outstanding, expected none", $time, pending_res.size());
    end
    $display("Sent %0d requests, checked %0d results across %0d stale limit writes (0, 1, 65535 incl.)",
             n_req, n_res, n_cfg);
    $display("Outcomes: added %0d, full %0d, found %0d, missed %0d, removed %0d, idle %0d, cleared %0d",
             seen[0], seen[1], seen[2], seen[3], seen[4], seen[5], seen[6]);
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
